/* rtl/core/fmp_pkg.sv */
package fmp_pkg;

    // field widths and pipeline shape
    localparam int EXP_BITS = 31;
    localparam int IN_W     = 31;
    localparam int VAL_W    = 30;
    localparam int NUM_STG  = (EXP_BITS < IN_W) ? EXP_BITS : IN_W;
    localparam int STG_LAT  = 5;
    localparam int PIPE_LAT = NUM_STG * STG_LAT;

    localparam logic [VAL_W-1:0] FIB_MOD = 30'd998244353;

    // Barrett constant floor(2^62 / P), 33 bits
    localparam logic [63:0] BAR_MU_FULL = (64'd1 << 62) / 64'd998244353;
    localparam logic [32:0] BAR_MU      = BAR_MU_FULL[32:0];

    typedef struct packed {
        logic [VAL_W-1:0] m00;
        logic [VAL_W-1:0] m01;
        logic [VAL_W-1:0] m10;
        logic [VAL_W-1:0] m11;
    } t_mat;

    localparam t_mat IDENT = '{m00: 30'd1, m01: 30'd0, m10: 30'd0, m11: 30'd1};

    // constant-only helpers, evaluated at elaboration
    function automatic logic [VAL_W-1:0] cmul(logic [VAL_W-1:0] x, logic [VAL_W-1:0] y);
        logic [59:0] p;
        p = 60'(x) * 60'(y);
        return 30'(p % 60'(FIB_MOD));
    endfunction

    function automatic logic [VAL_W-1:0] cadd(logic [VAL_W-1:0] x, logic [VAL_W-1:0] y);
        logic [VAL_W:0] s;
        s = 31'(x) + 31'(y);
        return 30'(s % 31'(FIB_MOD));
    endfunction

    // Fibonacci matrix raised to 2^k mod P
    function automatic t_mat pow2_mat(int k);
        t_mat m;
        t_mat s;
        m = '{m00: 30'd1, m01: 30'd1, m10: 30'd1, m11: 30'd0};
        for (int i = 0; i < k; i++) begin
            s.m00 = cadd(cmul(m.m00, m.m00), cmul(m.m01, m.m10));
            s.m01 = cadd(cmul(m.m00, m.m01), cmul(m.m01, m.m11));
            s.m10 = cadd(cmul(m.m10, m.m00), cmul(m.m11, m.m10));
            s.m11 = cadd(cmul(m.m10, m.m01), cmul(m.m11, m.m11));
            m = s;
        end
        return m;
    endfunction

endpackage

/* rtl/core/fmp_reduce.sv */
module fmp_reduce
    import fmp_pkg::*;
(
    input  logic             i_clk,
    input  logic [59:0]      i_x0,
    input  logic [59:0]      i_x1,
    output logic [VAL_W-1:0] o_r
);

    logic [60:0]      r_s;
    logic [31:0]      r_q;
    logic [31:0]      r_s2;
    logic [31:0]      r_qp;
    logic [31:0]      r_s3;
    logic [VAL_W-1:0] r_r;
    logic [31:0]      n_q;
    logic [63:0]      w_qm;
    logic [31:0]      w_diff;
    logic [VAL_W-1:0] n_r;

    // quotient estimate, low-word remainder with two-step correction
    always_comb begin
        w_qm   = 64'(r_s[60:30]) * 64'(BAR_MU);
        n_q    = w_qm[63:32];
        w_diff = r_s3 - r_qp;
        if (w_diff >= 32'(FIB_MOD) * 32'd2) begin
            n_r = 30'(w_diff - 32'(FIB_MOD) * 32'd2);
        end else if (w_diff >= 32'(FIB_MOD)) begin
            n_r = 30'(w_diff - 32'(FIB_MOD));
        end else begin
            n_r = 30'(w_diff);
        end
    end

    // sum, quotient, quotient times P, remainder
    always_ff @(posedge i_clk) begin
        r_s  <= 61'(i_x0) + 61'(i_x1);
        r_q  <= n_q;
        r_s2 <= r_s[31:0];
        r_qp <= 32'(r_q * 32'(FIB_MOD));
        r_s3 <= r_s2;
        r_r  <= n_r;
    end

    assign o_r = r_r;

endmodule

/* rtl/core/fmp_stage.sv */
module fmp_stage
    import fmp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [IN_W-1:0]  i_exp,
    input  logic             i_sel,
    input  t_mat             i_mat,
    input  logic [VAL_W-1:0] i_a,
    input  logic [VAL_W-1:0] i_b,
    output logic             o_valid,
    output logic [IN_W-1:0]  o_exp,
    output logic [VAL_W-1:0] o_a,
    output logic [VAL_W-1:0] o_b
);

    t_mat             w_mat;
    logic [59:0]      r_p0, r_p1, r_p2, r_p3;
    logic [STG_LAT-1:0] r_vld;
    logic [IN_W-1:0]  r_exp [STG_LAT];

    // row vector times power matrix, or identity when the bit is clear
    assign w_mat = i_sel ? i_mat : IDENT;

    always_ff @(posedge i_clk) begin
        r_p0 <= 60'(i_a) * 60'(w_mat.m00);
        r_p1 <= 60'(i_b) * 60'(w_mat.m10);
        r_p2 <= 60'(i_a) * 60'(w_mat.m01);
        r_p3 <= 60'(i_b) * 60'(w_mat.m11);
    end

    fmp_reduce u_red_a (.i_clk(i_clk), .i_x0(r_p0), .i_x1(r_p1), .o_r(o_a));
    fmp_reduce u_red_b (.i_clk(i_clk), .i_x0(r_p2), .i_x1(r_p3), .o_r(o_b));

    // valid and exponent travel alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[STG_LAT-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp[0] <= i_exp;
        for (int i = 1; i < STG_LAT; i++) begin
            r_exp[i] <= r_exp[i-1];
        end
    end

    assign o_valid = r_vld[STG_LAT-1];
    assign o_exp   = r_exp[STG_LAT-1];

endmodule

/* rtl/core/fibonacci_matrix_power_mod.sv */
// Fibonacci matrix power mod 998244353: pulse start with i_exponent = n and,
// once it has passed through every stage, o_valid pulses for one cycle with
// o_fib_next = F(n+1) mod P and o_fib_this = F(n) mod P. busy is always low:
// one new transaction may start every cycle and results come out in order,
// one per cycle, with fixed latency. The receiver cannot stall, so results
// must be captured in the cycle o_valid is high. The pipeline has one
// modular multiply stage per exponent bit.
module fibonacci_matrix_power_mod
    import fmp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [IN_W-1:0]  i_exponent,
    output logic             o_valid,
    output logic [VAL_W-1:0] o_fib_next,
    output logic [VAL_W-1:0] o_fib_this
);

    logic             s_vld [NUM_STG+1];
    logic [IN_W-1:0]  s_exp [NUM_STG+1];
    logic [VAL_W-1:0] s_a   [NUM_STG+1];
    logic [VAL_W-1:0] s_b   [NUM_STG+1];

    assign busy     = 1'b0;
    assign s_vld[0] = start;
    assign s_exp[0] = i_exponent;
    assign s_a[0]   = 30'd1;
    assign s_b[0]   = 30'd0;

    // one stage per exponent bit, each with its constant power matrix
    for (genvar k = 0; k < NUM_STG; k++) begin : g_stg
        fmp_stage u_stg (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(s_vld[k]),
            .i_exp  (s_exp[k]),
            .i_sel  (s_exp[k][k]),
            .i_mat  (pow2_mat(k)),
            .i_a    (s_a[k]),
            .i_b    (s_b[k]),
            .o_valid(s_vld[k+1]),
            .o_exp  (s_exp[k+1]),
            .o_a    (s_a[k+1]),
            .o_b    (s_b[k+1])
        );
    end

    assign o_valid    = s_vld[NUM_STG];
    assign o_fib_next = s_a[NUM_STG];
    assign o_fib_this = s_b[NUM_STG];

`ifndef SYNTH
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fib_next < FIB_MOD) && (o_fib_this < FIB_MOD))
        else $error("result out of range");
    a_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_fib_next == 30'd0 && o_fib_this == 30'd0))
        else $error("zero top row from invertible matrix");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");
`endif

endmodule
